/* design/rank_transform_unit_macros.svh */
// assertion macros for the rank transform unit
// used by the port checker; no other dependencies
`ifndef RANK_TRANSFORM_UNIT_MACROS_SVH
`define RANK_TRANSFORM_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RTU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rtu_pkg.sv */
// shared types and constants of the rank transform unit
// no dependencies
package rtu_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    // controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic key;
        logic scan;
        logic emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;
        logic elem_last;
        logic out_free;
    } sts_t;

endpackage

/* design/rtu_ctrl.sv */
// controller state machine of the rank transform unit
// depends on rtu_pkg
module rtu_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         final_element,
    input  rtu_pkg::sts_t sts,
    output logic         in_ready,
    output rtu_pkg::cmd_t cmd
);
    import rtu_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && final_element)
                begin
                    state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.elem_last ? ST_LOAD : ST_KEY;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_KEY:
            begin
                cmd.key = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/rtu_datapath.sv */
// datapath of the rank transform unit: value store, scan counters,
// compare-and-count unit and output register; depends on rtu_pkg
module rtu_datapath #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rtu_pkg::cmd_t                      cmd,
    output rtu_pkg::sts_t                      sts,
    input  logic signed [rtu_pkg::VALUE_W-1:0] element_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [rtu_pkg::RANK_W-1:0]  rank,
    output logic        [rtu_pkg::RANK_W-1:0]  position,
    output logic                               last_rank,
    output logic                               overflow
);
    import rtu_pkg::*;

    localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int RW    = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    // value store, one write port and two registered read ports
    logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0] key_reg;
    logic signed [VALUE_W-1:0] scan_data_reg;

    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;
    logic [AW-1:0]    elem_idx_reg;
    logic [AW-1:0]    scan_idx_reg;
    logic [CNT_W-1:0] smaller_reg;
    logic             cmp_en_reg;
    logic             out_valid_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] position_reg;
    logic             last_reg;
    logic             overflow_reg;

    logic             store_full;
    logic [RW-1:0]    rank_ext;
    logic [RW-1:0]    pos_ext;

    assign store_full = (count_reg >= CNT_W'(MAX_ELEMENTS));

    // status back to the controller
    assign sts.scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.elem_last = ((CNT_W'(elem_idx_reg) + CNT_W'(1)) == count_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // store write and read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load && !store_full)
        begin
            mem[count_reg[AW-1:0]] <= element_value;
        end
        key_reg       <= mem[elem_idx_reg];
        scan_data_reg <= mem[scan_idx_reg];
    end

    // list length and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.emit && sts.elem_last)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (store_full)
            begin
                dropped_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // element and scan indexes, compare-and-count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_idx_reg <= '0;
            scan_idx_reg <= '0;
            smaller_reg  <= '0;
            cmp_en_reg   <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan;
            if (cmd.key)
            begin
                scan_idx_reg <= '0;
                smaller_reg  <= '0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    scan_idx_reg <= scan_idx_reg + AW'(1);
                end
                if (cmp_en_reg && (scan_data_reg < key_reg))
                begin
                    smaller_reg <= smaller_reg + CNT_W'(1);
                end
            end
            if (cmd.emit)
            begin
                elem_idx_reg <= sts.elem_last ? '0 : elem_idx_reg + AW'(1);
            end
        end
    end

    // output word register
    assign rank_ext = RW'(smaller_reg);
    assign pos_ext  = RW'(elem_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rank_reg     <= rank_ext[RANK_W-1:0];
            position_reg <= pos_ext[RANK_W-1:0];
            last_reg     <= sts.elem_last;
            overflow_reg <= dropped_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign rank      = rank_reg;
    assign position  = position_reg;
    assign last_rank = last_reg;
    assign overflow  = overflow_reg;

endmodule

/* design/rank_transform_unit.sv */
// rank transform unit: loads one word per cycle, then per element counts
// the stored values below it with one comparator sweeping the store.
// after the final word each element in turn has its key read, the store
// swept by the single compare per cycle on the store's second read port
// and its count emitted as a result once the output register is free.
// reset (rst_n, async) empties the list; the store itself is not cleared.
module rank_transform_unit #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rtu_pkg::VALUE_W-1:0] element_value,
    input  logic                               final_element,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [rtu_pkg::RANK_W-1:0]  rank,
    output logic        [rtu_pkg::RANK_W-1:0]  position,
    output logic                               last_rank,
    output logic                               overflow
);
    import rtu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    rtu_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .final_element (final_element),
        .sts           (sts),
        .in_ready      (in_ready),
        .cmd           (cmd)
    );

    // store and compare datapath
    rtu_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rank          (rank),
        .position      (position),
        .last_rank     (last_rank),
        .overflow      (overflow)
    );

endmodule

/* design/rank_transform_unit_checker.sv */
// port checker for the rank transform unit, bound to the top level
// depends on rank_transform_unit_macros.svh
`include "rank_transform_unit_macros.svh"

module rank_transform_unit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       final_element,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] rank,
    input logic [5:0] position,
    input logic       last_rank,
    input logic       overflow
);

    // a stalled result word holds
    `RTU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(rank) && $stable(position) && $stable(last_rank) && $stable(overflow), "result word changed while stalled")

    // the final word closes the input until the list is emitted
    `RTU_ASSERT_NEXT(a_final_closes, clk, rst_n, in_valid && in_ready && final_element, !in_ready, "input open right after final word")

    // while loading, only the last result of a list may still wait
    `RTU_ASSERT_IMP(a_load_pending, clk, rst_n, in_ready && out_valid, last_rank, "non-last result pending while loading")

endmodule

bind rank_transform_unit rank_transform_unit_checker u_checker (.*);
